[sv/imm_pkg.sv]
package imm_pkg;

  localparam int DIM_W     = 4;
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 16;
  localparam int ACC_W     = 34;
  localparam int CFG_IDX_W = 2;

  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [1:0]              req_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam req_t REQ_WRITE_A = 2'd0;
  localparam req_t REQ_WRITE_B = 2'd1;
  localparam req_t REQ_COMPUTE = 2'd2;

  localparam cfg_idx_t CFG_ROWS_OF_A  = 2'd0;
  localparam cfg_idx_t CFG_INNER_SIZE = 2'd1;
  localparam cfg_idx_t CFG_COLS_OF_B  = 2'd2;

  localparam dim_t DIM_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CLEAR,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_WAIT,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_COMPUTE_REQ,
    CND_EMPTY_RUN,
    CND_NK_ZERO,
    CND_K_MORE,
    CND_OUT_BUSY,
    CND_RUN_DONE
  } cond_t;

  typedef struct packed {
    logic in_rdy;
    logic ij_clr;
    logic acc_clr;
    logic k_clr;
    logic mul_en;
    logic k_inc;
    logic acc_en;
    logic emit;
    logic ij_adv;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jump_to;
    step_t next_seq;
  } uword_t;

  typedef struct packed {
    logic compute_req;
    logic empty_run;
    logic nk_zero;
    logic k_more;
    logic out_busy;
    logic run_done;
  } stat_t;

  typedef struct packed {
    dim_t nr;
    dim_t nk;
    dim_t nc;
  } dims_t;

  // Microprogram: one control word per step, a conditional jump and a fall-through step.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.ctrl.in_rdy = 1'b1;
        w.cond        = CND_COMPUTE_REQ;
        w.jump_to     = ST_START;
        w.next_seq    = ST_IDLE;
      end
      ST_START: begin
        w.ctrl.ij_clr = 1'b1;
        w.cond        = CND_EMPTY_RUN;
        w.jump_to     = ST_IDLE;
        w.next_seq    = ST_CLEAR;
      end
      ST_CLEAR: begin
        w.ctrl.acc_clr = 1'b1;
        w.ctrl.k_clr   = 1'b1;
        w.cond         = CND_NK_ZERO;
        w.jump_to      = ST_WAIT;
        w.next_seq     = ST_READ;
      end
      ST_READ: begin
        w.cond     = CND_NEVER;
        w.jump_to  = ST_MUL;
        w.next_seq = ST_MUL;
      end
      ST_MUL: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.k_inc  = 1'b1;
        w.cond        = CND_NEVER;
        w.jump_to     = ST_ACC;
        w.next_seq    = ST_ACC;
      end
      ST_ACC: begin
        w.ctrl.acc_en = 1'b1;
        w.cond        = CND_K_MORE;
        w.jump_to     = ST_MUL;
        w.next_seq    = ST_WAIT;
      end
      ST_WAIT: begin
        w.cond     = CND_OUT_BUSY;
        w.jump_to  = ST_WAIT;
        w.next_seq = ST_EMIT;
      end
      ST_EMIT: begin
        w.ctrl.emit   = 1'b1;
        w.ctrl.ij_adv = 1'b1;
        w.cond        = CND_RUN_DONE;
        w.jump_to     = ST_IDLE;
        w.next_seq    = ST_CLEAR;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/imm_channels.sv]
interface imm_in_if;
  logic              valid;
  logic              ready;
  imm_pkg::req_t     req_type;
  imm_pkg::idx_t     elem_row;
  imm_pkg::idx_t     elem_col;
  imm_pkg::val_t     elem_value;

  modport source (output valid, output req_type, output elem_row, output elem_col,
                  output elem_value, input ready);
  modport sink (input valid, input req_type, input elem_row, input elem_col,
                input elem_value, output ready);
endinterface

interface imm_out_if;
  logic              valid;
  logic              ready;
  imm_pkg::idx_t     out_row;
  imm_pkg::idx_t     out_col;
  imm_pkg::acc_t     product_value;
  logic              last_of_run;

  modport source (output valid, output out_row, output out_col, output product_value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_row, input out_col, input product_value,
                input last_of_run, output ready);
endinterface

interface imm_cfg_if;
  logic              valid;
  logic              ready;
  imm_pkg::cfg_idx_t index;
  imm_pkg::dim_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/imm_ram.sv]
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/imm_sequencer.sv]
module imm_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  imm_pkg::stat_t stat,
  output imm_pkg::ctrl_t ctrl
);

  imm_pkg::step_t  step_r;
  imm_pkg::step_t  step_nxt;
  imm_pkg::uword_t uword;
  logic            cond_hit;

  always_comb begin
    uword = imm_pkg::ucode(step_r);
  end

  always_comb begin
    unique case (uword.cond)
      imm_pkg::CND_NEVER:       cond_hit = 1'b0;
      imm_pkg::CND_COMPUTE_REQ: cond_hit = stat.compute_req;
      imm_pkg::CND_EMPTY_RUN:   cond_hit = stat.empty_run;
      imm_pkg::CND_NK_ZERO:     cond_hit = stat.nk_zero;
      imm_pkg::CND_K_MORE:      cond_hit = stat.k_more;
      imm_pkg::CND_OUT_BUSY:    cond_hit = stat.out_busy;
      imm_pkg::CND_RUN_DONE:    cond_hit = stat.run_done;
      default:                  cond_hit = 1'b0;
    endcase
    step_nxt = cond_hit ? uword.jump_to : uword.next_seq;
  end

  always_comb begin
    ctrl = uword.ctrl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= imm_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[sv/imm_datapath.sv]
module imm_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  imm_pkg::ctrl_t  ctrl,
  input  imm_pkg::dims_t  dims,
  output imm_pkg::stat_t  stat,
  imm_in_if.sink          in_ch,
  imm_out_if.source       out_ch
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;
  localparam int SW    = ((PW > imm_pkg::ACC_W) ? PW : imm_pkg::ACC_W) + 1;
  localparam int AccW  = imm_pkg::ACC_W;

  logic [IW-1:0]            i_r, i_nxt;
  logic [IW-1:0]            j_r, j_nxt;
  imm_pkg::dim_t            k_r, k_nxt;
  logic                     in_acc, in_range, we_a, we_b;
  logic [AW-1:0]            wr_addr, rd_addr_a, rd_addr_b, addr_a, addr_b;
  logic [ELEM_WIDTH-1:0]    wr_data, rd_a, rd_b;
  logic signed [PW-1:0]     prod_r;
  logic signed [SW-1:0]     sum;
  imm_pkg::acc_t            acc_sat, acc_r, acc_nxt;
  logic                     i_last, j_last;
  logic                     out_valid_r, out_valid_nxt;
  imm_pkg::idx_t            out_row_r, out_col_r;
  imm_pkg::acc_t            out_val_r;
  logic                     out_last_r;

  assign in_ch.ready = ctrl.in_rdy;
  assign in_acc      = in_ch.valid && ctrl.in_rdy;
  assign in_range    = (imm_pkg::dim_t'(in_ch.elem_row) < imm_pkg::dim_t'(MAX_DIM)) &&
                       (imm_pkg::dim_t'(in_ch.elem_col) < imm_pkg::dim_t'(MAX_DIM));
  assign we_a        = in_acc && in_range && (in_ch.req_type == imm_pkg::REQ_WRITE_A);
  assign we_b        = in_acc && in_range && (in_ch.req_type == imm_pkg::REQ_WRITE_B);
  assign wr_data     = ELEM_WIDTH'(in_ch.elem_value);
  assign wr_addr     = AW'(in_ch.elem_row[IW-1:0]) * AW'(MAX_DIM) + AW'(in_ch.elem_col[IW-1:0]);
  assign rd_addr_a   = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r[IW-1:0]);
  assign rd_addr_b   = AW'(k_r[IW-1:0]) * AW'(MAX_DIM) + AW'(j_r);
  assign addr_a      = ctrl.in_rdy ? wr_addr : rd_addr_a;
  assign addr_b      = ctrl.in_rdy ? wr_addr : rd_addr_b;

  imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (addr_a),
    .wdata (wr_data),
    .rdata (rd_a)
  );

  imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (addr_b),
    .wdata (wr_data),
    .rdata (rd_b)
  );

  assign i_last = imm_pkg::dim_t'(i_r) == (dims.nr - imm_pkg::dim_t'(1));
  assign j_last = imm_pkg::dim_t'(j_r) == (dims.nc - imm_pkg::dim_t'(1));

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (ctrl.ij_clr) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (ctrl.ij_adv) begin
      if (j_last) begin
        j_nxt = '0;
        i_nxt = i_r + IW'(1);
      end else begin
        j_nxt = j_r + IW'(1);
      end
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (ctrl.k_clr) begin
      k_nxt = '0;
    end else if (ctrl.k_inc) begin
      k_nxt = k_r + imm_pkg::dim_t'(1);
    end
  end

  // The sum saturates to the accumulator range when the bits above its sign disagree.
  always_comb begin
    sum = SW'(acc_r) + SW'(prod_r);
    if ((sum[SW-1:AccW-1] == '0) || (sum[SW-1:AccW-1] == '1)) begin
      acc_sat = sum[AccW-1:0];
    end else if (sum[SW-1]) begin
      acc_sat = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(AccW-1){1'b1}}};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_en) begin
      acc_nxt = acc_sat;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (ctrl.mul_en) begin
      prod_r <= $signed(rd_a) * $signed(rd_b);
    end
    if (ctrl.emit) begin
      out_row_r  <= imm_pkg::idx_t'(i_r);
      out_col_r  <= imm_pkg::idx_t'(j_r);
      out_val_r  <= acc_r;
      out_last_r <= i_last && j_last;
    end
  end

  assign stat.compute_req = in_acc && (in_ch.req_type == imm_pkg::REQ_COMPUTE);
  assign stat.empty_run   = (dims.nr == '0) || (dims.nc == '0);
  assign stat.nk_zero     = dims.nk == '0;
  assign stat.k_more      = k_r < dims.nk;
  assign stat.out_busy    = out_valid_r && !out_ch.ready;
  assign stat.run_done    = i_last && j_last;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.last_of_run   = out_last_r;

endmodule

[sv/integer_matrix_multiply_core.sv]
// Integer matrix multiplier with a microcoded sequencer.
// The input channel carries one request per beat: a write of one element of A
// or of B at a given row and column, or a compute request. Writes are
// accepted back to back; a write outside the stores is
// dropped. A compute request forms C = A times B over the configured sizes and
// sends one beat per C element in row-major order, the final one marked last.
// Each C element runs through the sequencer steps clear, one read, then a
// multiply step and an accumulate step per inner term through the two
// single-port stores, then hand-over; when the inner size is zero, the read,
// multiply and accumulate steps are skipped. Each request adds a start step.
// Sums saturate to 34 bits. The configuration channel is always ready and is
// to be written only while no request is in progress.
// When the receiver stalls, the sequencer holds with the next product ready
// until the output register is free; no input is taken during a compute run.
// Synchronous reset returns the sequencer to idle, empties the output register
// and sets all three sizes to eight. Store contents are undefined until written.
module integer_matrix_multiply_core #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  imm_in_if.sink    in_ch,
  imm_out_if.source out_ch,
  imm_cfg_if.sink   cfg_ch
);

  imm_pkg::dim_t  rows_r, inner_r, cols_r;
  imm_pkg::dims_t dims;
  imm_pkg::ctrl_t ctrl;
  imm_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= imm_pkg::DIM_RESET;
      inner_r <= imm_pkg::DIM_RESET;
      cols_r  <= imm_pkg::DIM_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        imm_pkg::CFG_ROWS_OF_A:  rows_r  <= cfg_ch.data;
        imm_pkg::CFG_INNER_SIZE: inner_r <= cfg_ch.data;
        imm_pkg::CFG_COLS_OF_B:  cols_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign dims.nr = (rows_r > imm_pkg::dim_t'(MAX_DIM)) ? imm_pkg::dim_t'(MAX_DIM) : rows_r;
  assign dims.nk = (inner_r > imm_pkg::dim_t'(MAX_DIM)) ? imm_pkg::dim_t'(MAX_DIM) : inner_r;
  assign dims.nc = (cols_r > imm_pkg::dim_t'(MAX_DIM)) ? imm_pkg::dim_t'(MAX_DIM) : cols_r;

  imm_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  imm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .dims   (dims),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
